>>> design/cfn_pkg.sv
// ----------------------------------------------------------------------------
// cfn_pkg
// Shared types, constants and calendar functions for the calendar field
// normaliser: controller/datapath command and status, month lengths, leap rule.
// ----------------------------------------------------------------------------
package cfn_pkg;

  localparam int SEC_W      = 12;
  localparam int MIN_W      = 12;
  localparam int HOUR_W     = 10;
  localparam int DAY_W      = 13;
  localparam int MON_W      = 4;
  localparam int YEAR_W     = 10;

  // internal widths, sized for the largest carries
  localparam int MIN_ACC_W  = 13;  // up to 4095 + 68
  localparam int HOUR_ACC_W = 11;  // up to 1023 + 69
  localparam int DAY_ACC_W  = 14;  // -4096 .. 4095 + 45
  localparam int YEAR_ACC_W = 12;  // signed, about -12 .. 1036
  localparam int QUO_W      = 7;   // largest quotient is 69

  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOUR_PER_DAY  = 24;
  localparam int MON_PER_YEAR  = 12;
  localparam int YEAR_MAX      = 1023;

  // reciprocal multiply: floor(x * M >> 18) is exact for x < 2^18 / (M*d - 2^18)
  localparam int RECIP_SHIFT = 18;
  localparam int MUL_X_W     = 13;
  localparam int MUL_M_W     = 14;
  localparam int MUL_P_W     = MUL_X_W + MUL_M_W;
  localparam logic [MUL_M_W-1:0] RECIP_60 = 14'd4370;
  localparam logic [MUL_M_W-1:0] RECIP_24 = 14'd10923;

  localparam logic [4:0] MON_LEN_TAB [MON_PER_YEAR] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // century years (as offsets from 1900) within reach that are not leap years
  localparam int N_SKIP = 8;
  localparam logic signed [YEAR_ACC_W-1:0] SKIP_CENTURY [N_SKIP] = '{
    12'sd0, 12'sd200, 12'sd300, 12'sd400, 12'sd600, 12'sd700, 12'sd800, 12'sd1000
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEC_Q,
    OP_SEC_R,
    OP_MIN_Q,
    OP_MIN_R,
    OP_HOUR_Q,
    OP_HOUR_R,
    OP_MONTH,
    OP_WALK
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC_Q,
    ST_SEC_R,
    ST_MIN_Q,
    ST_MIN_R,
    ST_HOUR_Q,
    ST_HOUR_R,
    ST_MONTH,
    ST_WALK,
    ST_DONE
  } state_t;

  // 1900 is a multiple of four, so the low bits of the offset decide that test
  function automatic logic is_leap(input logic signed [YEAR_ACC_W-1:0] off);
    logic skip;
    skip = 1'b0;
    for (int i = 0; i < N_SKIP; i++) begin
      if (off == SKIP_CENTURY[i]) skip = 1'b1;
    end
    return (off[1:0] == 2'b00) && !skip;
  endfunction

  function automatic logic [4:0] month_length(input logic signed [YEAR_ACC_W-1:0] off,
                                              input logic [MON_W-1:0] mon);
    logic [4:0] d;
    d = (mon < MON_W'(MON_PER_YEAR)) ? MON_LEN_TAB[mon] : 5'd31;
    if (mon == MON_W'(1) && is_leap(off)) d = d + 5'd1;
    return d;
  endfunction

endpackage

>>> design/cfn_datapath.sv
// ----------------------------------------------------------------------------
// cfn_datapath
// Field registers, shared reciprocal multiplier for the time carries and the
// one-month-per-cycle day walk.
// ----------------------------------------------------------------------------
module cfn_datapath
  import cfn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic [SEC_W-1:0]         in_second,
  input  logic [MIN_W-1:0]         in_minute,
  input  logic [HOUR_W-1:0]        in_hour,
  input  logic signed [DAY_W-1:0]  in_day,
  input  logic [MON_W-1:0]         in_month,
  input  logic [YEAR_W-1:0]        in_year,
  output logic [5:0]               out_second,
  output logic [5:0]               out_minute,
  output logic [4:0]               out_hour,
  output logic [4:0]               out_day,
  output logic [MON_W-1:0]         out_month,
  output logic [YEAR_W-1:0]        out_year,
  output logic                     out_year_overflow
);

  logic [SEC_W-1:0]                sec_r,  sec_nxt;
  logic [MIN_ACC_W-1:0]            min_r,  min_nxt;
  logic [HOUR_ACC_W-1:0]           hour_r, hour_nxt;
  logic signed [DAY_ACC_W-1:0]     day_r,  day_nxt;
  logic [MON_W-1:0]                mon_r,  mon_nxt;
  logic signed [YEAR_ACC_W-1:0]    year_r, year_nxt;
  logic [QUO_W-1:0]                quo_r,  quo_nxt;

  logic [MUL_X_W-1:0]              mul_x;
  logic [MUL_M_W-1:0]              mul_m;
  logic [MUL_P_W-1:0]              prod;
  logic [MUL_X_W-1:0]              quo_ext;
  logic [MUL_X_W-1:0]              quo_x60;
  logic [MUL_X_W-1:0]              quo_x24;

  logic [MON_W-1:0]                prev_mon, next_mon;
  logic signed [YEAR_ACC_W-1:0]    prev_year, next_year;
  logic [4:0]                      len_cur, len_prev;
  logic signed [DAY_ACC_W-1:0]     len_cur_s, len_prev_s;
  logic                            day_pos, day_over;

  // shared multiplier operand select
  always_comb begin
    mul_x = MUL_X_W'(sec_r);
    mul_m = RECIP_60;
    case (cmd.op)
      OP_MIN_Q: begin
        mul_x = min_r;
        mul_m = RECIP_60;
      end
      OP_HOUR_Q: begin
        mul_x = MUL_X_W'(hour_r);
        mul_m = RECIP_24;
      end
      default: begin
        mul_x = MUL_X_W'(sec_r);
        mul_m = RECIP_60;
      end
    endcase
  end

  assign prod    = MUL_P_W'(mul_x) * MUL_P_W'(mul_m);
  assign quo_ext = MUL_X_W'(quo_r);
  assign quo_x60 = quo_ext * MUL_X_W'(SEC_PER_MIN);
  assign quo_x24 = quo_ext * MUL_X_W'(HOUR_PER_DAY);

  // neighbouring months for the walk
  always_comb begin
    if (mon_r == '0) begin
      prev_mon  = MON_W'(MON_PER_YEAR - 1);
      prev_year = year_r - YEAR_ACC_W'(1);
    end else begin
      prev_mon  = mon_r - MON_W'(1);
      prev_year = year_r;
    end
    if (mon_r == MON_W'(MON_PER_YEAR - 1)) begin
      next_mon  = '0;
      next_year = year_r + YEAR_ACC_W'(1);
    end else begin
      next_mon  = mon_r + MON_W'(1);
      next_year = year_r;
    end
  end

  assign len_cur    = month_length(year_r, mon_r);
  assign len_prev   = month_length(prev_year, prev_mon);
  assign len_cur_s  = $signed({{(DAY_ACC_W-5){1'b0}}, len_cur});
  assign len_prev_s = $signed({{(DAY_ACC_W-5){1'b0}}, len_prev});
  assign day_pos    = (day_r > 0);
  assign day_over   = (day_r > len_cur_s);

  // a backward walk always stops inside the month it lands in
  assign status.walk_done = day_pos && !day_over;

  always_comb begin
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    quo_nxt  = quo_r;
    if (cmd.load) begin
      sec_nxt  = in_second;
      min_nxt  = MIN_ACC_W'(in_minute);
      hour_nxt = HOUR_ACC_W'(in_hour);
      day_nxt  = DAY_ACC_W'(in_day);
      mon_nxt  = in_month;
      year_nxt = $signed(YEAR_ACC_W'(in_year));
    end else begin
      case (cmd.op)
        OP_SEC_Q, OP_MIN_Q, OP_HOUR_Q: begin
          quo_nxt = prod[RECIP_SHIFT +: QUO_W];
        end
        OP_SEC_R: begin
          sec_nxt = SEC_W'(MUL_X_W'(sec_r) - quo_x60);
          min_nxt = min_r + MIN_ACC_W'(quo_r);
        end
        OP_MIN_R: begin
          min_nxt  = min_r - quo_x60;
          hour_nxt = hour_r + HOUR_ACC_W'(quo_r);
        end
        OP_HOUR_R: begin
          hour_nxt = HOUR_ACC_W'(MUL_X_W'(hour_r) - quo_x24);
          day_nxt  = day_r + $signed(DAY_ACC_W'(quo_r));
        end
        OP_MONTH: begin
          if (mon_r >= MON_W'(MON_PER_YEAR)) begin
            mon_nxt  = mon_r - MON_W'(MON_PER_YEAR);
            year_nxt = year_r + YEAR_ACC_W'(1);
          end
        end
        OP_WALK: begin
          if (!day_pos) begin
            day_nxt  = day_r + len_prev_s;
            mon_nxt  = prev_mon;
            year_nxt = prev_year;
          end else if (day_over) begin
            day_nxt  = day_r - len_cur_s;
            mon_nxt  = next_mon;
            year_nxt = next_year;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    day_r  <= day_nxt;
    mon_r  <= mon_nxt;
    year_r <= year_nxt;
    quo_r  <= quo_nxt;
  end

  // year saturation
  always_comb begin
    out_year_overflow = 1'b0;
    out_year          = year_r[YEAR_W-1:0];
    if (year_r < 0) begin
      out_year          = '0;
      out_year_overflow = 1'b1;
    end else if (year_r > YEAR_ACC_W'(YEAR_MAX)) begin
      out_year          = YEAR_W'(YEAR_MAX);
      out_year_overflow = 1'b1;
    end
  end

  assign out_second = sec_r[5:0];
  assign out_minute = min_r[5:0];
  assign out_hour   = hour_r[4:0];
  assign out_day    = day_r[4:0];
  assign out_month  = mon_r;

  a_sec_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.load && cmd.op == OP_SEC_R) |=> (sec_r < SEC_W'(SEC_PER_MIN)))
    else $error("seconds not reduced below 60");

  a_min_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.load && cmd.op == OP_MIN_R) |=> (min_r < MIN_ACC_W'(MIN_PER_HOUR)))
    else $error("minutes not reduced below 60");

  a_hour_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.load && cmd.op == OP_HOUR_R) |=> (hour_r < HOUR_ACC_W'(HOUR_PER_DAY)))
    else $error("hours not reduced below 24");

  a_walk_month: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.load && cmd.op == OP_WALK) |-> (mon_r < MON_W'(MON_PER_YEAR)))
    else $error("month index out of range during day walk");

endmodule

>>> design/cfn_ctrl.sv
// ----------------------------------------------------------------------------
// cfn_ctrl
// Sequencer for the calendar field normaliser: steps the datapath through the
// time carries, the month fold and the day walk, then strobes the result.
// ----------------------------------------------------------------------------
module cfn_ctrl
  import cfn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_valid
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SEC_Q;
      ST_SEC_Q:  state_nxt = ST_SEC_R;
      ST_SEC_R:  state_nxt = ST_MIN_Q;
      ST_MIN_Q:  state_nxt = ST_MIN_R;
      ST_MIN_R:  state_nxt = ST_HOUR_Q;
      ST_HOUR_Q: state_nxt = ST_HOUR_R;
      ST_HOUR_R: state_nxt = ST_MONTH;
      ST_MONTH:  state_nxt = ST_WALK;
      ST_WALK:   if (status.walk_done) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SEC_Q:  cmd.op = OP_SEC_Q;
      ST_SEC_R:  cmd.op = OP_SEC_R;
      ST_MIN_Q:  cmd.op = OP_MIN_Q;
      ST_MIN_R:  cmd.op = OP_MIN_R;
      ST_HOUR_Q: cmd.op = OP_HOUR_Q;
      ST_HOUR_R: cmd.op = OP_HOUR_R;
      ST_MONTH:  cmd.op = OP_MONTH;
      ST_WALK:   cmd.op = OP_WALK;
      ST_DONE:   out_valid = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!busy && start))
    else $error("datapath load outside an accepted transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_walk_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && status.walk_done) |=> out_valid)
    else $error("finished walk not followed by result");

endmodule

>>> design/calendar_field_normalizer_unit.sv
// ----------------------------------------------------------------------------
// calendar_field_normalizer_unit
// Normalises a broken-down Gregorian date and time (years since 1900): time
// carries, month fold, day walk and year saturation with overflow flag.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. The result appears
// on the out_ ports for exactly one cycle, marked by out_valid. Before it,
// the seconds, minutes and hours carries each take a quotient and a remainder
// step through one shared reciprocal multiplier, a month index of 12 or more
// is folded into the year, and the day walk steps one month per cycle through
// the month-length table until the day lies inside its month; it crosses 0
// months for an in-range day and up to about 137 for the largest inputs.
// busy stays high until the result cycle ends; the receiver cannot stall and
// must take the result in that cycle. The next transfer can be taken in the
// cycle after the result.
module calendar_field_normalizer_unit
  import cfn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [SEC_W-1:0]         in_second,
  input  logic [MIN_W-1:0]         in_minute,
  input  logic [HOUR_W-1:0]        in_hour,
  input  logic signed [DAY_W-1:0]  in_day,
  input  logic [MON_W-1:0]         in_month,
  input  logic [YEAR_W-1:0]        in_year,
  output logic                     out_valid,
  output logic [5:0]               out_second,
  output logic [5:0]               out_minute,
  output logic [4:0]               out_hour,
  output logic [4:0]               out_day,
  output logic [MON_W-1:0]         out_month,
  output logic [YEAR_W-1:0]        out_year,
  output logic                     out_year_overflow
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cfn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cfn_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_second         (in_second),
    .in_minute         (in_minute),
    .in_hour           (in_hour),
    .in_day            (in_day),
    .in_month          (in_month),
    .in_year           (in_year),
    .out_second        (out_second),
    .out_minute        (out_minute),
    .out_hour          (out_hour),
    .out_day           (out_day),
    .out_month         (out_month),
    .out_year          (out_year),
    .out_year_overflow (out_year_overflow)
  );

endmodule
